>>> design/ranked_vector_table_engine_macros.svh
// assertion macros for the ranked vector table engine
// used by the controller
`ifndef RANKED_VECTOR_TABLE_ENGINE_MACROS_SVH
`define RANKED_VECTOR_TABLE_ENGINE_MACROS_SVH

// check a property on every rising clock edge outside reset
`define RVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

>>> design/rvte_pkg.sv
// shared types and codes for the ranked vector table engine
// no dependencies
package rvte_pkg;
    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_REMOVE_RANGE = 3'd1,
        FN_REMOVE_ONE = 3'd2,
        FN_FIND = 3'd3,
        FN_DEDUP = 3'd4,
        FN_UNIQUIFY = 3'd5,
        FN_DISORDER = 3'd6,
        FN_READ = 3'd7
    } t_func;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_RANK = 2'd2;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_RD_A = 3'd1,   // read address a into data a register
        CMD_RD_B = 3'd2,   // read address b into data b register
        CMD_WR_V = 3'd3,   // write input value at address a
        CMD_WR_B = 3'd4,   // write data b register at address a
        CMD_WR_DA = 3'd5   // write data a register at address b
    } t_cmd;
endpackage

>>> design/rvte_datapath.sv
// element store memory with one write and one registered read port
// depends on rvte_pkg
module rvte_datapath
    import rvte_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW = 6
) (
    input  logic             i_clk,
    input  t_cmd             i_cmd,
    input  logic [AW-1:0]    i_addr_a,
    input  logic [AW-1:0]    i_addr_b,
    input  logic [WIDTH-1:0] i_value,
    output logic [WIDTH-1:0] o_data_a,
    output logic [WIDTH-1:0] o_data_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_data_a;
    logic [WIDTH-1:0] r_data_b;
    logic [WIDTH-1:0] r_rdata;
    logic [AW-1:0]    w_raddr;

    assign w_raddr = (i_cmd == CMD_RD_B) ? i_addr_b : i_addr_a;
    assign r_rdata = r_mem[w_raddr];

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_RD_A: r_data_a <= r_rdata;
            CMD_RD_B: r_data_b <= r_rdata;
            CMD_WR_V: r_mem[i_addr_a] <= i_value;
            CMD_WR_B: r_mem[i_addr_a] <= r_data_b;
            CMD_WR_DA: r_mem[i_addr_b] <= r_data_a;
            default: ;
        endcase
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;
endmodule

>>> design/rvte_ctrl.sv
// sequencer for all eight operations, drives the store datapath
// depends on rvte_pkg and the assertion macros
`include "ranked_vector_table_engine_macros.svh"
module rvte_ctrl
    import rvte_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [2:0]       i_func,
    input  logic [6:0]       i_rank_lo,
    input  logic [6:0]       i_rank_hi,
    input  logic [31:0]      i_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_rank_out,
    output logic [31:0]      o_value_out,
    output logic [6:0]       o_count_out,
    output logic [1:0]       o_error,
    output logic [6:0]       o_size_out,
    output t_cmd             o_cmd,
    output logic [AW-1:0]    o_addr_a,
    output logic [AW-1:0]    o_addr_b,
    output logic [WIDTH-1:0] o_wval,
    input  logic [WIDTH-1:0] i_data_a,
    input  logic [WIDTH-1:0] i_data_b
);
    typedef enum logic [4:0] {
        S_IDLE, S_INS_RD, S_INS_WR, S_INS_PUT,
        S_CUT_RD, S_CUT_WR,
        S_RM1_RD, S_RM1_WAIT,
        S_FIND_RD, S_FIND_CMP,
        S_DD_RDI, S_DD_RDJ, S_DD_CMP,
        S_UQ_RDI, S_UQ_CMP, S_UQ_WR,
        S_DO_RDA, S_DO_RDB, S_DO_CMP,
        S_RD_RD, S_RD_WAIT,
        S_DONE
    } t_state;

    t_state          r_state;
    t_func           r_func;
    logic [CW-1:0]   r_size;
    logic [CW-1:0]   r_i;     // walking index
    logic [CW-1:0]   r_j;     // second index
    logic [CW-1:0]   r_k;     // deduplicate position held across a cut
    logic [CW-1:0]   r_lo;
    logic [WIDTH-1:0] r_val;
    logic            r_ovalid;
    logic [7:0]      r_rank;
    logic [31:0]     r_vout;
    logic [6:0]      r_cnt;
    logic [1:0]      r_err;
    // output register, frees the sequencer while a result waits
    logic [7:0]      r_orank;
    logic [31:0]     r_ovout;
    logic [6:0]      r_ocnt;
    logic [1:0]      r_oerr;
    logic [6:0]      r_osize;
    t_cmd            r_cmd;
    logic [AW-1:0]   r_aa;
    logic [AW-1:0]   r_ab;
    logic [CW:0]     w_lo_x;
    logic [CW:0]     w_hi_x;
    logic [CW:0]     w_sz_x;
    logic [WIDTH-1:0] w_mval;
    logic            w_take;

    assign w_lo_x = {{(CW+1-7){1'b0}}, i_rank_lo};
    assign w_hi_x = {{(CW+1-7){1'b0}}, i_rank_hi};
    assign w_sz_x = {1'b0, r_size};
    assign w_mval = WIDTH'(i_value);
    assign w_take = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size <= '0;
            r_ovalid <= 1'b0;
            r_cmd <= CMD_NONE;
        end else begin
            r_cmd <= CMD_NONE;
            if (r_ovalid && !i_stall && r_state != S_DONE) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_func <= t_func'(i_func);
                        r_lo <= CW'(i_rank_lo);
                        r_val <= w_mval;
                        r_rank <= '0;
                        r_vout <= '0;
                        r_cnt <= '0;
                        r_err <= ERR_OK;
                        r_state <= S_DONE;
                        case (t_func'(i_func))
                            FN_INSERT: begin
                                if (w_sz_x >= (CW+1)'(DEPTH)) r_err <= ERR_FULL;
                                else if (w_lo_x > w_sz_x) r_err <= ERR_RANK;
                                else begin
                                    r_i <= r_size;
                                    r_state <= S_INS_RD;
                                end
                            end
                            FN_REMOVE_RANGE, FN_FIND: begin
                                if (w_lo_x > w_hi_x || w_hi_x > w_sz_x) r_err <= ERR_RANK;
                                else if (t_func'(i_func) == FN_FIND) begin
                                    r_i <= CW'(i_rank_hi);
                                    r_state <= S_FIND_RD;
                                end else begin
                                    r_cnt <= 7'(i_rank_hi - i_rank_lo);
                                    r_i <= CW'(i_rank_lo);
                                    r_j <= CW'(i_rank_hi);
                                    r_state <= S_CUT_RD;
                                end
                            end
                            FN_REMOVE_ONE, FN_READ: begin
                                if (w_lo_x >= w_sz_x) r_err <= ERR_RANK;
                                else begin
                                    r_aa <= AW'(i_rank_lo);
                                    r_cmd <= CMD_RD_A;
                                    r_state <= (t_func'(i_func) == FN_READ) ? S_RD_WAIT
                                                                            : S_RM1_WAIT;
                                end
                            end
                            FN_DEDUP: begin
                                r_i <= CW'(1);
                                r_state <= S_DD_RDI;
                            end
                            FN_UNIQUIFY: begin
                                if (r_size != '0) begin
                                    r_i <= CW'(1);
                                    r_j <= '0;
                                    r_state <= S_UQ_RDI;
                                end
                            end
                            default: begin
                                r_i <= CW'(1);
                                r_state <= S_DO_RDA;
                            end
                        endcase
                    end
                end
                // insert: shift entries up from the top
                S_INS_RD: begin
                    if (r_i > r_lo) begin
                        r_ab <= AW'(r_i - 1'b1);
                        r_cmd <= CMD_RD_B;
                        r_state <= S_INS_WR;
                    end else begin
                        r_aa <= AW'(r_lo);
                        r_cmd <= CMD_WR_V;
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_WR: begin
                    r_aa <= AW'(r_i);
                    r_cmd <= CMD_WR_B;
                    r_i <= r_i - 1'b1;
                    r_state <= S_INS_RD;
                end
                S_INS_PUT: begin
                    r_size <= r_size + 1'b1;
                    r_rank <= 8'(r_lo);
                    r_state <= S_DONE;
                end
                // cut [i, j): copy down
                S_CUT_RD: begin
                    if (r_j < r_size) begin
                        r_ab <= AW'(r_j);
                        r_cmd <= CMD_RD_B;
                        r_state <= S_CUT_WR;
                    end else begin
                        r_size <= r_i;
                        if (r_func == FN_DEDUP) begin
                            r_i <= r_k;
                            r_state <= S_DD_RDI;
                        end else r_state <= S_DONE;
                    end
                end
                S_CUT_WR: begin
                    r_aa <= AW'(r_i);
                    r_cmd <= CMD_WR_B;
                    r_i <= r_i + 1'b1;
                    r_j <= r_j + 1'b1;
                    r_state <= S_CUT_RD;
                end
                S_RM1_WAIT: r_state <= S_RM1_RD;
                S_RM1_RD: begin
                    r_vout <= 32'(i_data_a);
                    r_cnt <= 7'd1;
                    r_i <= r_lo;
                    r_j <= r_lo + 1'b1;
                    r_state <= S_CUT_RD;
                end
                S_RD_WAIT: r_state <= S_RD_RD;
                S_RD_RD: begin
                    r_vout <= 32'(i_data_a);
                    r_state <= S_DONE;
                end
                // find: scan down from hi
                S_FIND_RD: begin
                    if (r_i > r_lo) begin
                        r_ab <= AW'(r_i - 1'b1);
                        r_cmd <= CMD_RD_B;
                        r_i <= r_i - 1'b1;
                        r_state <= S_FIND_CMP;
                    end else begin
                        r_rank <= 8'(r_lo) - 8'd1;
                        r_state <= S_DONE;
                    end
                end
                S_FIND_CMP: begin
                    if (r_cmd == CMD_NONE) begin
                        if (i_data_b == r_val) begin
                            r_rank <= 8'(r_i);
                            r_state <= S_DONE;
                        end else r_state <= S_FIND_RD;
                    end
                end
                // deduplicate: element i against all below
                S_DD_RDI: begin
                    if (r_i < r_size) begin
                        r_aa <= AW'(r_i);
                        r_cmd <= CMD_RD_A;
                        r_j <= '0;
                        r_state <= S_DD_RDJ;
                    end else r_state <= S_DONE;
                end
                S_DD_RDJ: begin
                    if (r_cmd == CMD_NONE) begin
                        if (r_j < r_i) begin
                            r_ab <= AW'(r_j);
                            r_cmd <= CMD_RD_B;
                            r_state <= S_DD_CMP;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_DD_RDI;
                        end
                    end
                end
                S_DD_CMP: begin
                    if (r_cmd == CMD_NONE) begin
                        if (i_data_b == i_data_a) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_k <= r_i;
                            r_j <= r_i + 1'b1;
                            r_state <= S_CUT_RD;
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_state <= S_DD_RDJ;
                        end
                    end
                end
                // uniquify: j is last kept, i scans
                S_UQ_RDI: begin
                    if (r_i < r_size) begin
                        r_aa <= AW'(r_j);
                        r_ab <= AW'(r_i);
                        r_cmd <= CMD_RD_A;
                        r_state <= S_UQ_CMP;
                    end else begin
                        r_cnt <= 7'(r_size - (r_j + 1'b1));
                        r_size <= r_j + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_UQ_CMP: begin
                    if (r_cmd == CMD_RD_A) r_cmd <= CMD_RD_B;
                    else if (r_cmd == CMD_NONE) r_state <= S_UQ_WR;
                end
                S_UQ_WR: begin
                    if (i_data_a != i_data_b) begin
                        r_aa <= AW'(r_j + 1'b1);
                        r_j <= r_j + 1'b1;
                        r_cmd <= CMD_WR_B;
                    end
                    r_i <= r_i + 1'b1;
                    r_state <= S_UQ_RDI;
                end
                // count descending adjacent pairs
                S_DO_RDA: begin
                    if (r_i < r_size) begin
                        r_aa <= AW'(r_i - 1'b1);
                        r_ab <= AW'(r_i);
                        r_cmd <= CMD_RD_A;
                        r_state <= S_DO_RDB;
                    end else r_state <= S_DONE;
                end
                S_DO_RDB: begin
                    if (r_cmd == CMD_RD_A) r_cmd <= CMD_RD_B;
                    else if (r_cmd == CMD_NONE) r_state <= S_DO_CMP;
                end
                S_DO_CMP: begin
                    if (i_data_a > i_data_b) r_cnt <= r_cnt + 1'b1;
                    r_i <= r_i + 1'b1;
                    r_state <= S_DO_RDA;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_orank <= r_rank;
                        r_ovout <= r_vout;
                        r_ocnt <= r_cnt;
                        r_oerr <= r_err;
                        r_osize <= 7'(r_size);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_rank_out = r_orank;
    assign o_value_out = r_ovout;
    assign o_count_out = r_ocnt;
    assign o_error = r_oerr;
    assign o_size_out = r_osize;
    assign o_cmd = r_cmd;
    assign o_addr_a = r_aa;
    assign o_addr_b = r_ab;
    assign o_wval = r_val;

    `RVT_ASSERT(a_size_bound, i_clk, i_rst_n, w_sz_x <= (CW+1)'(DEPTH), "size above depth")
    `RVT_ASSERT(a_idle_nostall, i_clk, i_rst_n, (r_state == S_IDLE) == !o_stall, "stall mismatch")
    `RVT_ASSERT(a_err_nosize, i_clk, i_rst_n, (o_valid && o_error != ERR_OK) |-> $stable(r_size) || $past(r_state) != S_DONE, "size moved on error")
endmodule

>>> design/ranked_vector_table_engine.sv
// ranked vector table engine: one request at a time; an error leaves the table unchanged,
// read fetches one word, insert shifts entries from the rank up, remove range and remove one
// move entries above the span down, find scans down from hi, uniquify compares each entry
// with the last kept, disordered walks adjacent pairs, deduplicate each with all below it.
// next input transfer in the cycle after the result enters the output register.
// synchronous active-low reset empties the store (count to zero); stored words undefined.
module ranked_vector_table_engine
    import rvte_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [6:0]  i_rank_lo,
    input  logic [6:0]  i_rank_hi,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_rank_out,
    output logic [31:0] o_value_out,
    output logic [6:0]  o_count_out,
    output logic [1:0]  o_error,
    output logic [6:0]  o_size_out
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1) > 7 ? $clog2(DEPTH + 1) : 7;

    t_cmd             w_cmd;
    logic [AW-1:0]    w_aa;
    logic [AW-1:0]    w_ab;
    logic [WIDTH-1:0] w_wval;
    logic [WIDTH-1:0] w_da;
    logic [WIDTH-1:0] w_db;

    rvte_ctrl #(.DEPTH(DEPTH), .WIDTH(WIDTH), .AW(AW), .CW(CW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_rank_lo(i_rank_lo), .i_rank_hi(i_rank_hi),
        .i_value(i_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_rank_out(o_rank_out), .o_value_out(o_value_out),
        .o_count_out(o_count_out), .o_error(o_error), .o_size_out(o_size_out),
        .o_cmd(w_cmd), .o_addr_a(w_aa), .o_addr_b(w_ab), .o_wval(w_wval),
        .i_data_a(w_da), .i_data_b(w_db)
    );

    rvte_datapath #(.DEPTH(DEPTH), .WIDTH(WIDTH), .AW(AW)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_addr_a(w_aa), .i_addr_b(w_ab),
        .i_value(w_wval), .o_data_a(w_da), .o_data_b(w_db)
    );
endmodule

>>> bench/ranked_vector_table_engine_test.sv
// self-checking bench for the ranked vector table engine: a directed table, then
// random requests, scored against an in-bench mirror or a fixed reply; needs rvte_pkg
module ranked_vector_table_engine_test;
    import rvte_pkg::*;

    localparam int SLOTS = 64;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic [7:0]  rank;
        logic [31:0] word;
        logic [6:0]  cnt;
        logic [1:0]  err;
        logic [6:0]  size;
    } reply_t;

    typedef struct {
        t_func       func;
        logic [6:0]  lo;
        logic [6:0]  hi;
        logic [31:0] word;
        bit          typed;
        reply_t      reply;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_func = 3'd0;
    logic [6:0]  i_rank_lo = 7'd0;
    logic [6:0]  i_rank_hi = 7'd0;
    logic [31:0] i_value = 32'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_rank_out;
    logic [31:0] o_value_out;
    logic [6:0]  o_count_out;
    logic [1:0]  o_error;
    logic [6:0]  o_size_out;

    // mirror of the table contents
    logic [31:0] table_words [SLOTS];
    int          table_fill;

    reply_t pending_replies [$];
    row_t   steps [$];
    int     failures;
    int     replies_seen;
    bit     quiet;

    ranked_vector_table_engine dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic void drop_span(int lo, int hi);
        while (hi < table_fill) begin
            table_words[lo] = table_words[hi];
            lo++;
            hi++;
        end
        table_fill = lo;
    endfunction

    function automatic int scan_back(logic [31:0] w, int lo, int hi);
        while (hi > lo) begin
            hi--;
            if (table_words[hi] == w) return hi;
        end
        return lo - 1;
    endfunction

    // applies one request to the mirror and returns the reply it should give
    function automatic reply_t apply_request(t_func f, int lo, int hi, logic [31:0] w);
        reply_t r;
        int     i;
        int     k;
        r = '0;
        case (f)
            FN_INSERT: begin
                if (table_fill >= SLOTS) r.err = ERR_FULL;
                else if (lo > table_fill) r.err = ERR_RANK;
                else begin
                    for (i = table_fill; i > lo; i--) table_words[i] = table_words[i - 1];
                    table_words[lo] = w;
                    table_fill++;
                    r.rank = 8'(lo);
                end
            end
            FN_REMOVE_RANGE: begin
                if (lo > hi || hi > table_fill) r.err = ERR_RANK;
                else begin
                    r.cnt = 7'(hi - lo);
                    drop_span(lo, hi);
                end
            end
            FN_REMOVE_ONE: begin
                if (lo >= table_fill) r.err = ERR_RANK;
                else begin
                    r.word = table_words[lo];
                    drop_span(lo, lo + 1);
                    r.cnt = 7'd1;
                end
            end
            FN_FIND: begin
                if (lo > hi || hi > table_fill) r.err = ERR_RANK;
                else r.rank = 8'(scan_back(w, lo, hi));
            end
            FN_DEDUP: begin
                k = table_fill;
                i = 1;
                while (i < table_fill) begin
                    if (scan_back(table_words[i], 0, i) < 0) i++;
                    else drop_span(i, i + 1);
                end
                r.cnt = 7'(k - table_fill);
            end
            FN_UNIQUIFY: begin
                if (table_fill != 0) begin
                    k = 0;
                    for (i = 1; i < table_fill; i++) begin
                        if (table_words[k] != table_words[i]) begin
                            k++;
                            table_words[k] = table_words[i];
                        end
                    end
                    r.cnt = 7'(table_fill - (k + 1));
                    table_fill = k + 1;
                end
            end
            FN_DISORDER: begin
                for (i = 1; i < table_fill; i++)
                    if (table_words[i - 1] > table_words[i]) r.cnt++;
            end
            default: begin
                if (lo >= table_fill) r.err = ERR_RANK;
                else r.word = table_words[lo];
            end
        endcase
        r.size = 7'(table_fill);
        return r;
    endfunction

    function automatic void add_step(t_func f, int lo, int hi, logic [31:0] w, bit typed,
                                     reply_t r);
        row_t s;
        s.func = f;
        s.lo = 7'(lo);
        s.hi = 7'(hi);
        s.word = w;
        s.typed = typed;
        s.reply = r;
        steps.push_back(s);
    endfunction

    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'd0;
                1: return 32'hffff_ffff;
                default: return 32'($urandom_range(1, 7));
            endcase
        end
        return $urandom;
    endfunction

    // random request, biased to fill, drain or mix so the table visits empty and full
    function automatic row_t pick_request(int mode);
        row_t s;
        int   roll;
        int   lo;
        int   hi;
        roll = $urandom_range(0, 99);
        if (mode == 0) s.func = (roll < 80) ? FN_INSERT : t_func'($urandom_range(1, 7));
        else if (mode == 1) begin
            if (roll < 35) s.func = FN_REMOVE_ONE;
            else if (roll < 50) s.func = FN_REMOVE_RANGE;
            else s.func = t_func'($urandom_range(0, 7));
        end else begin
            if (roll < 3) s.func = FN_DEDUP;
            else if (roll < 30) s.func = FN_INSERT;
            else s.func = t_func'($urandom_range(1, 7));
        end
        if (s.func == FN_DEDUP && mode != 2 && $urandom_range(0, 3) != 0) s.func = FN_FIND;
        roll = $urandom_range(0, 99);
        if (roll < 85) lo = $urandom_range(0, table_fill);
        else if (roll < 95) lo = $urandom_range(0, 127);
        else lo = $urandom_range(0, 64);
        if (lo <= table_fill && $urandom_range(0, 9) != 0)
            hi = lo + $urandom_range(0, table_fill - lo);
        else hi = $urandom_range(0, 127);
        s.lo = 7'(lo);
        s.hi = 7'(hi);
        s.word = pick_word();
        if (s.func == FN_FIND && table_fill != 0 && $urandom_range(0, 1) == 0)
            s.word = table_words[$urandom_range(0, table_fill - 1)];
        s.typed = 1'b0;
        s.reply = '0;
        return s;
    endfunction

    task automatic offer(row_t s);
        int     gap;
        reply_t r;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func <= s.func;
        i_rank_lo <= s.lo;
        i_rank_hi <= s.hi;
        i_value <= s.word;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        r = apply_request(s.func, s.lo, s.hi, s.word);
        pending_replies.push_back(s.typed ? s.reply : r);
    endtask

    // stimulus
    initial begin
        reply_t none;
        int     n;
        int     mode;
        none = '0;
        table_fill = 0;
        failures = 0;
        quiet = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table cases, then cases on a small filled table
        add_step(FN_READ, 0, 0, 0, 1, '{8'd0, 32'd0, 7'd0, ERR_RANK, 7'd0});
        add_step(FN_UNIQUIFY, 0, 0, 0, 1, none);
        add_step(FN_DEDUP, 0, 0, 0, 1, none);
        add_step(FN_DISORDER, 0, 0, 0, 1, none);
        add_step(FN_REMOVE_ONE, 0, 0, 0, 1, '{8'd0, 32'd0, 7'd0, ERR_RANK, 7'd0});
        add_step(FN_FIND, 0, 0, 7, 1, '{8'hff, 32'd0, 7'd0, ERR_OK, 7'd0});
        add_step(FN_INSERT, 1, 0, 3, 1, '{8'd0, 32'd0, 7'd0, ERR_RANK, 7'd0});
        add_step(FN_INSERT, 0, 0, 32'hffff_ffff, 1, '{8'd0, 32'd0, 7'd0, ERR_OK, 7'd1});
        add_step(FN_READ, 0, 0, 0, 1, '{8'd0, 32'hffff_ffff, 7'd0, ERR_OK, 7'd1});
        add_step(FN_INSERT, 1, 0, 0, 0, none);
        add_step(FN_INSERT, 0, 0, 5, 0, none);
        add_step(FN_INSERT, 3, 0, 5, 0, none);
        add_step(FN_INSERT, 2, 0, 0, 0, none);
        add_step(FN_INSERT, 2, 0, 0, 0, none);
        add_step(FN_FIND, 0, 6, 5, 0, none);
        add_step(FN_FIND, 2, 2, 5, 0, none);
        add_step(FN_FIND, 3, 2, 5, 1, '{8'd0, 32'd0, 7'd0, ERR_RANK, 7'd6});
        add_step(FN_FIND, 0, 127, 5, 1, '{8'd0, 32'd0, 7'd0, ERR_RANK, 7'd6});
        add_step(FN_REMOVE_RANGE, 4, 4, 0, 1, '{8'd0, 32'd0, 7'd0, ERR_OK, 7'd6});
        add_step(FN_DISORDER, 0, 0, 0, 0, none);
        add_step(FN_UNIQUIFY, 0, 0, 0, 0, none);
        add_step(FN_DEDUP, 0, 0, 0, 0, none);
        add_step(FN_READ, 127, 0, 0, 1, '{8'd0, 32'd0, 7'd0, ERR_RANK, 7'd3});
        add_step(FN_REMOVE_ONE, 1, 0, 0, 0, none);
        add_step(FN_REMOVE_RANGE, 0, 2, 0, 0, none);
        foreach (steps[i]) offer(steps[i]);

        mode = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 120 == 0) mode = (n / 120) % 3;
            if (n == RANDOM_ITEMS - 150) quiet = 1'b1;
            offer(pick_request(mode));
        end
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) $display("ranked_vector_table_engine regression: pass");
        else $display("ranked_vector_table_engine regression: fail");
        $finish;
    end

    // result side: scoring and stall bursts, with one long hold-off
    initial begin
        int     stall_left;
        bit     held;
        reply_t want;
        reply_t got;
        stall_left = 0;
        held = 1'b0;
        replies_seen = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got = '{o_rank_out, o_value_out, o_count_out, o_error, o_size_out};
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected transfer, actual %p", $time, got);
                    failures++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.rank !== want.rank || got.word !== want.word ||
                        got.cnt !== want.cnt || got.err !== want.err ||
                        got.size !== want.size) begin
                        $display("%0t: mismatch, expected %p actual %p", $time, want, got);
                        failures++;
                    end
                end
            end
            if (!held && replies_seen >= 400) begin
                held = 1'b1;
                stall_left = 1500;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        #300_000_000;
        $display("ranked_vector_table_engine regression: fail");
        $finish;
    end
endmodule
